/* rtl/bpu_pkg.sv */
package bpu_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int PRICE_W_DEF = 32;
  localparam int QTY_W_DEF   = 48;
  localparam int CMD_W       = 3;
  localparam int RANK_W      = 6;
  localparam int CODE_W      = 3;
  localparam int LEVELS_W    = 7;

  localparam logic [CMD_W-1:0] CMD_APPLY     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLR_SIDE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLR_BOTH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd4;

  typedef enum logic [2:0] {
    OP_APPLY,
    OP_CLR_SIDE,
    OP_CLR_BOTH,
    OP_READ,
    OP_LOOKUP,
    OP_NONE
  } op_t;

  typedef enum logic [CODE_W-1:0] {
    CH_NONE   = 3'd0,
    CH_INSERT = 3'd1,
    CH_UPDATE = 3'd2,
    CH_REMOVE = 3'd3,
    CH_DROP   = 3'd4
  } chg_t;

  typedef enum logic {
    BK_CMP,
    BK_UPD
  } bk_state_t;

  typedef struct packed {
    logic apply;
    logic clear;
    logic lookup;
  } row_ctl_t;

  typedef struct packed {
    logic found;
    logic same;
    logic drop;
    logic full;
    logic rd_hit;
  } row_st_t;

endpackage

/* rtl/price_level_book_update_unit.sv */
// with the queue empty, a start beat is queued, compared in BK_CMP, applied in BK_UPD, then registered onto out_strobe
// the back end takes one command at a time, through the compare pass and the shift pass
// of the cell rows; a two-entry queue absorbs bursts, busy is high while it is full
// reset: synchronous active-low rst_n empties the queue and both level counts
// results appear for exactly one cycle on out_strobe; the receiver cannot stall
module price_level_book_update_unit import bpu_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int PRICE_W = PRICE_W_DEF,
  parameter int QTY_W   = QTY_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic                in_book_side,
  input  logic [PRICE_W-1:0]  in_level_price,
  input  logic [QTY_W-1:0]    in_level_quantity,
  input  logic [RANK_W-1:0]   in_rank_index,
  output logic                out_strobe,
  output logic [CODE_W-1:0]   out_change_code,
  output logic                out_evicted,
  output logic [PRICE_W-1:0]  out_best_bid_price,
  output logic [QTY_W-1:0]    out_best_bid_qty,
  output logic [PRICE_W-1:0]  out_best_ask_price,
  output logic [QTY_W-1:0]    out_best_ask_qty,
  output logic [LEVELS_W-1:0] out_bid_levels,
  output logic [LEVELS_W-1:0] out_ask_levels,
  output logic                out_read_valid,
  output logic [PRICE_W-1:0]  out_read_price,
  output logic [QTY_W-1:0]    out_read_qty
);

  logic               q_valid, q_pop, hd_ask;
  op_t                hd_op;
  logic [PRICE_W-1:0] hd_price;
  logic [QTY_W-1:0]   hd_qty;
  logic [RANK_W-1:0]  hd_rank;

  bpu_front #(.PRICE_W(PRICE_W), .QTY_W(QTY_W)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
    .in_book_side(in_book_side), .in_level_price(in_level_price),
    .in_level_quantity(in_level_quantity), .in_rank_index(in_rank_index),
    .q_pop(q_pop), .q_valid(q_valid), .hd_op(hd_op), .hd_ask(hd_ask),
    .hd_price(hd_price), .hd_qty(hd_qty), .hd_rank(hd_rank)
  );

  bpu_back #(.DEPTH(DEPTH), .PRICE_W(PRICE_W), .QTY_W(QTY_W)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .hd_op(hd_op), .hd_ask(hd_ask),
    .hd_price(hd_price), .hd_qty(hd_qty), .hd_rank(hd_rank), .q_pop(q_pop),
    .out_strobe(out_strobe), .out_change_code(out_change_code),
    .out_evicted(out_evicted), .out_best_bid_price(out_best_bid_price),
    .out_best_bid_qty(out_best_bid_qty), .out_best_ask_price(out_best_ask_price),
    .out_best_ask_qty(out_best_ask_qty), .out_bid_levels(out_bid_levels),
    .out_ask_levels(out_ask_levels), .out_read_valid(out_read_valid),
    .out_read_price(out_read_price), .out_read_qty(out_read_qty)
  );

endmodule

/* rtl/bpu_front.sv */
module bpu_front import bpu_pkg::*; #(
  parameter int PRICE_W = PRICE_W_DEF,
  parameter int QTY_W   = QTY_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic                in_book_side,
  input  logic [PRICE_W-1:0]  in_level_price,
  input  logic [QTY_W-1:0]    in_level_quantity,
  input  logic [RANK_W-1:0]   in_rank_index,
  input  logic                q_pop,
  output logic                q_valid,
  output op_t                 hd_op,
  output logic                hd_ask,
  output logic [PRICE_W-1:0]  hd_price,
  output logic [QTY_W-1:0]    hd_qty,
  output logic [RANK_W-1:0]   hd_rank
);

  op_t                op_r    [2];
  logic               ask_r   [2];
  logic [PRICE_W-1:0] price_r [2];
  logic [QTY_W-1:0]   qty_r   [2];
  logic [RANK_W-1:0]  rank_r  [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;
  logic               push;
  op_t                op_dec;

  always_comb begin
    unique case (in_cmd)
      CMD_APPLY:    op_dec = OP_APPLY;
      CMD_CLR_SIDE: op_dec = OP_CLR_SIDE;
      CMD_CLR_BOTH: op_dec = OP_CLR_BOTH;
      CMD_READ:     op_dec = OP_READ;
      CMD_LOOKUP:   op_dec = OP_LOOKUP;
      default:      op_dec = OP_NONE;
    endcase
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      op_r[wp_r]    <= op_dec;
      ask_r[wp_r]   <= in_book_side;
      price_r[wp_r] <= in_level_price;
      qty_r[wp_r]   <= in_level_quantity;
      rank_r[wp_r]  <= in_rank_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assign hd_op    = op_r[rp_r];
  assign hd_ask   = ask_r[rp_r];
  assign hd_price = price_r[rp_r];
  assign hd_qty   = qty_r[rp_r];
  assign hd_rank  = rank_r[rp_r];

endmodule

/* rtl/bpu_row.sv */
module bpu_row import bpu_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int PRICE_W = PRICE_W_DEF,
  parameter int QTY_W   = QTY_W_DEF,
  parameter bit ASK     = 1'b0,
  localparam int CW     = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmp_en,
  input  logic [PRICE_W-1:0]  price_in,
  input  logic [QTY_W-1:0]    qty_in,
  input  logic [RANK_W-1:0]   rank_in,
  input  row_ctl_t            ctl,
  output row_st_t             st,
  output logic [PRICE_W-1:0]  best_price,
  output logic [QTY_W-1:0]    best_qty,
  output logic [CW-1:0]       count,
  output logic [PRICE_W-1:0]  rd_price,
  output logic [QTY_W-1:0]    rd_qty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = (IW > RANK_W) ? IW : RANK_W;

  logic [PRICE_W-1:0] price_r [DEPTH];
  logic [QTY_W-1:0]   qty_r   [DEPTH];
  logic [PRICE_W-1:0] prv_p   [DEPTH];
  logic [QTY_W-1:0]   prv_q   [DEPTH];
  logic [PRICE_W-1:0] nxt_p   [DEPTH];
  logic [QTY_W-1:0]   nxt_q   [DEPTH];
  logic [DEPTH-1:0]   ahd_r, eq_r, qeq_r, rk_r, sel;
  logic [PRICE_W-1:0] new_price_r;
  logic [QTY_W-1:0]   new_qty_r;
  logic [CW-1:0]      count_r;
  logic               remove, do_rem, do_upd, do_ins;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      new_price_r <= price_in;
      new_qty_r   <= qty_in;
    end
  end

  assign remove = (new_qty_r == '0);
  assign st.found  = |eq_r;
  assign st.same   = |(eq_r & qeq_r);
  assign st.full   = (count_r == CW'(DEPTH));
  assign st.drop   = st.full && ahd_r[DEPTH-1];
  assign sel       = ctl.lookup ? eq_r : rk_r;
  assign st.rd_hit = |sel;

  assign do_rem = ctl.apply && remove && st.found;
  assign do_upd = ctl.apply && !remove && st.found;
  assign do_ins = ctl.apply && !remove && !st.found && !st.drop;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic valid;
    assign valid = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      assign prv_p[i] = new_price_r;
      assign prv_q[i] = new_qty_r;
    end else begin : g_mid
      assign prv_p[i] = ahd_r[i-1] ? new_price_r : price_r[i-1];
      assign prv_q[i] = ahd_r[i-1] ? new_qty_r : qty_r[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign nxt_p[i] = price_r[i];
      assign nxt_q[i] = qty_r[i];
    end else begin : g_inner
      assign nxt_p[i] = price_r[i+1];
      assign nxt_q[i] = qty_r[i+1];
    end

    // compare flags, taken from the queue head
    always_ff @(posedge clk) begin
      if (cmp_en) begin
        ahd_r[i] <= valid && (ASK ? (price_r[i] < price_in) : (price_r[i] > price_in));
        eq_r[i]  <= valid && (price_r[i] == price_in);
        qeq_r[i] <= (qty_r[i] == qty_in);
        rk_r[i]  <= valid && (RW'(rank_in) == RW'(i));
      end
    end

    // on a remove or insert, cells behind the hit or insert point move as one; an update rewrites the hit quantity
    always_ff @(posedge clk) begin
      if (do_rem && !ahd_r[i]) begin
        price_r[i] <= nxt_p[i];
        qty_r[i]   <= nxt_q[i];
      end else if (do_upd && eq_r[i]) begin
        qty_r[i] <= new_qty_r;
      end else if (do_ins && !ahd_r[i]) begin
        price_r[i] <= prv_p[i];
        qty_r[i]   <= prv_q[i];
      end
    end
  end

  always_comb begin
    rd_price = '0;
    rd_qty   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_price = rd_price | (price_r[i] & {PRICE_W{sel[i]}});
      rd_qty   = rd_qty | (qty_r[i] & {QTY_W{sel[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clear) begin
      count_r <= '0;
    end else if (do_rem) begin
      count_r <= count_r - CW'(1);
    end else if (do_ins && !st.full) begin
      count_r <= count_r + CW'(1);
    end
  end

  assign count      = count_r;
  assign best_price = (count_r != '0) ? price_r[0] : '0;
  assign best_qty   = (count_r != '0) ? qty_r[0] : '0;

endmodule

/* rtl/bpu_back.sv */
module bpu_back import bpu_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int PRICE_W = PRICE_W_DEF,
  parameter int QTY_W   = QTY_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  op_t                 hd_op,
  input  logic                hd_ask,
  input  logic [PRICE_W-1:0]  hd_price,
  input  logic [QTY_W-1:0]    hd_qty,
  input  logic [RANK_W-1:0]   hd_rank,
  output logic                q_pop,
  output logic                out_strobe,
  output logic [CODE_W-1:0]   out_change_code,
  output logic                out_evicted,
  output logic [PRICE_W-1:0]  out_best_bid_price,
  output logic [QTY_W-1:0]    out_best_bid_qty,
  output logic [PRICE_W-1:0]  out_best_ask_price,
  output logic [QTY_W-1:0]    out_best_ask_qty,
  output logic [LEVELS_W-1:0] out_bid_levels,
  output logic [LEVELS_W-1:0] out_ask_levels,
  output logic                out_read_valid,
  output logic [PRICE_W-1:0]  out_read_price,
  output logic [QTY_W-1:0]    out_read_qty
);

  localparam int CW = $clog2(DEPTH + 1);

  bk_state_t          state_r, state_nxt;
  op_t                op_r;
  logic               ask_r, rem_r, upd;
  row_ctl_t           bid_ctl, ask_ctl;
  row_st_t            bid_st, ask_st, sst;
  logic [CW-1:0]      bid_cnt, ask_cnt;
  logic [PRICE_W-1:0] bid_rp, ask_rp;
  logic [QTY_W-1:0]   bid_rq, ask_rq;
  logic               strobe_r, evict_r, rv_r;
  chg_t               code_r, code_nxt;
  logic               evict_nxt, is_rd;
  logic [PRICE_W-1:0] rp_r;
  logic [QTY_W-1:0]   rq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_CMP;
    else state_r <= state_nxt;
  end

  always_comb begin
    q_pop     = 1'b0;
    upd       = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      BK_CMP: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_UPD;
        end
      end
      BK_UPD: begin
        upd       = 1'b1;
        state_nxt = BK_CMP;
      end
      default: state_nxt = BK_CMP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r  <= hd_op;
      ask_r <= hd_ask;
      rem_r <= (hd_qty == '0);
    end
  end

  assign bid_ctl.apply  = upd && (op_r == OP_APPLY) && !ask_r;
  assign bid_ctl.clear  = upd && (((op_r == OP_CLR_SIDE) && !ask_r) || (op_r == OP_CLR_BOTH));
  assign bid_ctl.lookup = (op_r == OP_LOOKUP);
  assign ask_ctl.apply  = upd && (op_r == OP_APPLY) && ask_r;
  assign ask_ctl.clear  = upd && (((op_r == OP_CLR_SIDE) && ask_r) || (op_r == OP_CLR_BOTH));
  assign ask_ctl.lookup = (op_r == OP_LOOKUP);

  bpu_row #(.DEPTH(DEPTH), .PRICE_W(PRICE_W), .QTY_W(QTY_W), .ASK(1'b0)) u_bid (
    .clk(clk), .rst_n(rst_n), .cmp_en(q_pop), .price_in(hd_price), .qty_in(hd_qty),
    .rank_in(hd_rank), .ctl(bid_ctl), .st(bid_st), .best_price(out_best_bid_price),
    .best_qty(out_best_bid_qty), .count(bid_cnt), .rd_price(bid_rp), .rd_qty(bid_rq)
  );

  bpu_row #(.DEPTH(DEPTH), .PRICE_W(PRICE_W), .QTY_W(QTY_W), .ASK(1'b1)) u_ask (
    .clk(clk), .rst_n(rst_n), .cmp_en(q_pop), .price_in(hd_price), .qty_in(hd_qty),
    .rank_in(hd_rank), .ctl(ask_ctl), .st(ask_st), .best_price(out_best_ask_price),
    .best_qty(out_best_ask_qty), .count(ask_cnt), .rd_price(ask_rp), .rd_qty(ask_rq)
  );

  assign sst   = ask_r ? ask_st : bid_st;
  assign is_rd = (op_r == OP_READ) || (op_r == OP_LOOKUP);

  always_comb begin
    code_nxt  = CH_NONE;
    evict_nxt = 1'b0;
    if (op_r == OP_APPLY) begin
      priority if (rem_r) begin
        code_nxt = sst.found ? CH_REMOVE : CH_NONE;
      end else if (sst.found) begin
        code_nxt = sst.same ? CH_NONE : CH_UPDATE;
      end else if (sst.drop) begin
        code_nxt = CH_DROP;
      end else begin
        code_nxt  = CH_INSERT;
        evict_nxt = sst.full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else strobe_r <= upd;
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      code_r  <= code_nxt;
      evict_r <= evict_nxt;
      rv_r    <= is_rd && sst.rd_hit;
      rp_r    <= is_rd ? (ask_r ? ask_rp : bid_rp) : '0;
      rq_r    <= is_rd ? (ask_r ? ask_rq : bid_rq) : '0;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_change_code = code_r;
  assign out_evicted     = evict_r;
  assign out_read_valid  = rv_r;
  assign out_read_price  = rp_r;
  assign out_read_qty    = rq_r;
  assign out_bid_levels  = LEVELS_W'(bid_cnt);
  assign out_ask_levels  = LEVELS_W'(ask_cnt);

`ifndef SYNTHESIS
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r) else $error("back-to-back result strobes");
  a_upd_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> strobe_r) else $error("update without result");
  a_bid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    bid_cnt <= CW'(DEPTH)) else $error("bid count overflow");
  a_ask_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ask_cnt <= CW'(DEPTH)) else $error("ask count overflow");
`endif

endmodule
